>>> rtl/dslp_pkg.sv
// ----------------------------------------------------------------------------
// dslp_pkg
// Shared types and constants for the two-button debounce and press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dslp_pkg;

	localparam int NUM_BUTTONS = 2;
	localparam int BTN_TARE    = 0;
	localparam int BTN_TIMER   = 1;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = CFG_W'(50);
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(1000);

	// what one lane reports for one tick
	typedef struct packed {
		logic short_ev;
		logic long_ev;
		logic held;
	} lane_evt_t;

	// one result transaction
	typedef struct packed {
		logic tare_short;
		logic tare_long;
		logic timer_short;
		logic timer_long;
		logic tare_held;
		logic timer_held;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/dslp_in_if.sv
// ----------------------------------------------------------------------------
// dslp_in_if
// Tick channel: raw active-low levels of both buttons.
// ----------------------------------------------------------------------------
`default_nettype none

interface dslp_in_if;
	logic valid;
	logic ready;
	logic tare_level;
	logic timer_level;

	modport source (output valid, output tare_level, output timer_level, input ready);
	modport sink   (input valid, input tare_level, input timer_level, output ready);
endinterface

`default_nettype wire

>>> rtl/dslp_out_if.sv
// ----------------------------------------------------------------------------
// dslp_out_if
// Result channel: press events and debounced held state per tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface dslp_out_if;
	logic valid;
	logic ready;
	logic tare_short;
	logic tare_long;
	logic timer_short;
	logic timer_long;
	logic tare_held;
	logic timer_held;

	modport source (
		output valid, output tare_short, output tare_long, output timer_short,
		output timer_long, output tare_held, output timer_held, input ready
	);
	modport sink (
		input valid, input tare_short, input tare_long, input timer_short,
		input timer_long, input tare_held, input timer_held, output ready
	);
endinterface

`default_nettype wire

>>> rtl/dslp_cfg_if.sv
// ----------------------------------------------------------------------------
// dslp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dslp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dslp_pkg::CFG_IDX_W-1:0] index;
	logic [dslp_pkg::CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/debounced_short_long_press_core.sv
// ----------------------------------------------------------------------------
// debounced_short_long_press_core
// Two-button debouncer with short- and long-press event detection.
//
// Usage:
//   in_ch   one transaction per millisecond tick, carrying the raw active-low
//           levels of the tare and timer buttons.
//   out_ch  exactly one result transaction per tick: short/long event flags
//           for each button plus the debounced held state.
//   cfg_ch  register writes; index 0 = debounce ticks, 1 = long-press ticks.
//           Always ready. Other indexes are dropped. Write only while idle.
// Result: registered, valid in the cycle after tick acceptance.
// Throughput: one tick per clock. The output register is drained and
//   refilled on the same edge, so in_ch stays ready while out_ch is taken.
// Stall: while a result sits unread in the output register, in_ch.ready
//   drops; no tick is lost or reordered.
// Reset: both buttons read as released, all counters and flags zero,
//   debounce = 50 ticks, long press = 1000 ticks; output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_short_long_press_core #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dslp_in_if.sink    in_ch,
	dslp_out_if.source out_ch,
	dslp_cfg_if.sink   cfg_ch
);
	import dslp_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;

	logic             step;
	logic             in_ready;
	logic             out_valid;
	logic             raw [NUM_BUTTONS];
	lane_evt_t        evt [NUM_BUTTONS];
	result_t          result;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_DEBOUNCE:   debounce_q   <= cfg_ch.data;
				REG_LONG_PRESS: long_press_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// a tick is consumed when the handshake completes
	assign in_ch.ready = in_ready;
	assign step        = in_ch.valid && in_ready;

	assign raw[BTN_TARE]  = in_ch.tare_level;
	assign raw[BTN_TIMER] = in_ch.timer_level;

	// one lane per button, fully independent
	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		dslp_lane #(
			.COUNT_BITS(COUNT_BITS)
		) u_lane (
			.clk              (clk),
			.arst_n           (arst_n),
			.step             (step),
			.level            (raw[b]),
			.debounce_ticks   (debounce_q),
			.long_press_ticks (long_press_q),
			.evt              (evt[b])
		);
	end

	dslp_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.evt       (evt),
		.out_ready (out_ch.ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.result    (result)
	);

	assign out_ch.valid       = out_valid;
	assign out_ch.tare_short  = result.tare_short;
	assign out_ch.tare_long   = result.tare_long;
	assign out_ch.timer_short = result.timer_short;
	assign out_ch.timer_long  = result.timer_long;
	assign out_ch.tare_held   = result.tare_held;
	assign out_ch.timer_held  = result.timer_held;

endmodule

`default_nettype wire

>>> rtl/dslp_lane.sv
// ----------------------------------------------------------------------------
// dslp_lane
// One button: debounce counter, qualified level, hold counter, event logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dslp_lane #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic                       level,
	input  wire logic [dslp_pkg::CFG_W-1:0] debounce_ticks,
	input  wire logic [dslp_pkg::CFG_W-1:0] long_press_ticks,
	output dslp_pkg::lane_evt_t             evt
);
	import dslp_pkg::*;

	// compare width covers both counter and register
	localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

	logic                  last_raw_q;
	logic [COUNT_BITS-1:0] stable_q;
	logic                  qual_q;
	logic [COUNT_BITS-1:0] hold_q;
	logic                  long_done_q;

	logic [COUNT_BITS-1:0] stable_n;
	logic [COUNT_BITS-1:0] hold_inc;
	logic [COUNT_BITS-1:0] hold_n;
	logic                  settled;
	logic                  qual_chg;
	logic                  press;
	logic                  qual_rel;
	logic                  qual_n;
	logic                  ld_mid;
	logic                  ld_n;
	logic                  rel_long;
	logic                  fire_hold;

	always_comb begin
		hold_inc  = (hold_q == '1) ? hold_q : hold_q + 1'b1;
		if (level != last_raw_q) begin
			stable_n = '0;
		end else begin
			stable_n = (stable_q == '1) ? stable_q : stable_q + 1'b1;
		end
		settled   = CMP_W'(stable_n) >= CMP_W'(debounce_ticks);
		qual_chg  = settled && (level != qual_q);
		press     = qual_chg && !level;
		qual_rel  = qual_chg && level;
		hold_n    = press ? '0 : hold_inc;
		qual_n    = qual_chg ? level : qual_q;
		ld_mid    = press ? 1'b0 : long_done_q;
		rel_long  = CMP_W'(hold_inc) >= CMP_W'(long_press_ticks);
		fire_hold = settled && !qual_n && !ld_mid &&
			(CMP_W'(hold_n) >= CMP_W'(long_press_ticks));
		ld_n      = ld_mid | fire_hold;

		evt.short_ev = qual_rel && !rel_long;
		evt.long_ev  = (qual_rel && rel_long && !long_done_q) || fire_hold;
		evt.held     = !qual_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= 1'b1;
			stable_q    <= '0;
			qual_q      <= 1'b1;
			hold_q      <= '0;
			long_done_q <= 1'b0;
		end else if (step) begin
			last_raw_q  <= level;
			stable_q    <= stable_n;
			qual_q      <= qual_n;
			hold_q      <= hold_n;
			long_done_q <= ld_n;
		end
	end

	// a tick never reports both kinds of event
	a_evt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !(evt.short_ev && evt.long_ev))
		else $error("short and long fired on the same tick");

	// short only on a qualified release
	a_short_rel: assert property (@(posedge clk) disable iff (!arst_n)
		(step && evt.short_ev) |-> (level && !qual_q))
		else $error("short fired without a qualified release");

	// long-done flag only drops on a qualified press
	a_ld_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(long_done_q && !(step && press)) |=> long_done_q)
		else $error("long-done cleared without a press");

endmodule

`default_nettype wire

>>> rtl/dslp_merge.sv
// ----------------------------------------------------------------------------
// dslp_merge
// Gathers lane events into one result and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dslp_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire dslp_pkg::lane_evt_t evt [dslp_pkg::NUM_BUTTONS],
	input  wire logic                out_ready,
	output logic                     in_ready,
	output logic                     out_valid,
	output dslp_pkg::result_t        result
);
	import dslp_pkg::*;

	logic    valid_q;
	result_t result_q;
	result_t merged;

	always_comb begin
		merged.tare_short  = evt[BTN_TARE].short_ev;
		merged.tare_long   = evt[BTN_TARE].long_ev;
		merged.timer_short = evt[BTN_TIMER].short_ev;
		merged.timer_long  = evt[BTN_TIMER].long_ev;
		merged.tare_held   = evt[BTN_TARE].held;
		merged.timer_held  = evt[BTN_TIMER].held;
	end

	// take a new tick whenever the register is empty or being drained
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= merged;
		end
	end

endmodule

`default_nettype wire

>>> tb/debounced_short_long_press_core_tb.sv
// ----------------------------------------------------------------------------
// debounced_short_long_press_core_tb
// Self-checking bench for the two-button debounce and press detector.
// A directed table covers reset values, zero and full-scale settings,
// bounce, unmapped register writes and a short press after long fired.
// Random press/release episodes with bounce and noise follow, run under
// several debounce and long-press settings. A held soak fires long once
// and then stays quiet. Both channels stall in random bursts. Every
// result transaction is checked against a typed value or the in-bench model.
// ----------------------------------------------------------------------------
module debounced_short_long_press_core_tb;
	import dslp_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 11;
	localparam int COUNT_W       = 16;    // counter width handed to the core
	localparam int STALL_LIMIT   = 1000;  // cycles with no transaction at all
	localparam int SETTLE_CYCLES = 2;     // output register plus margin
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_TICKS   = 100;
	localparam int SLOW_TICKS    = 60;    // phase with full-scale debounce
	localparam int TAIL_TICKS    = 150;
	localparam int SOAK_TICKS    = 120;   // past the soak long threshold
	localparam int DIRECTED_ROWS = 27;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(15);
	localparam logic [CFG_W-1:0]     CFG_MAX         = '1;
	localparam logic [CFG_W-1:0]     SOAK_LONG       = CFG_W'(100);
	localparam logic [COUNT_W-1:0]   COUNT_MAX       = '1;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [CFG_W-1:0]       value;
		logic                   tare;
		logic                   timer;
		bit                     typed;   // use want instead of the model
		result_t                want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	dslp_in_if  in_ch ();
	dslp_out_if out_ch ();
	dslp_cfg_if cfg_ch ();

	debounced_short_long_press_core #(
		.COUNT_BITS(COUNT_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// ------------------------------------------------------------------
	// Directed table. want bit order: tare_short, tare_long, timer_short,
	// timer_long, tare_held, timer_held. Rows without a typed value are
	// checked against the model.
	// ------------------------------------------------------------------
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// reset settings: nothing qualifies on the first ticks
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b1, 1'b1, 1'b1, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b0, 1'b1, 6'b000000},
		// zero debounce, zero long time: long fires on the qualifying tick
		'{ROW_WRITE, REG_DEBOUNCE,    16'h0000, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_WRITE, REG_LONG_PRESS,  16'h0000, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b1, 6'b010010},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b1, 1'b0, 1'b1, 6'b000101},
		// writes to unmapped indexes are dropped
		'{ROW_WRITE, REG_UNMAPPED_HI, 16'hFFFF, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_WRITE, REG_UNMAPPED_LO, 16'h5A5A, 1'b1, 1'b1, 1'b0, 6'b000000},
		// long time of three ticks: tare long, timer released late
		'{ROW_WRITE, REG_LONG_PRESS,  16'h0003, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b0, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b0, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b0, 6'b000000},
		// long time raised while tare is held: release fires short
		'{ROW_WRITE, REG_LONG_PRESS,  16'h0064, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b1, 1'b1, 1'b0, 6'b000000},
		// debounce of two with a bounce on the tare press
		'{ROW_WRITE, REG_DEBOUNCE,    16'h0002, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b0, 6'b000000},
		// full-scale settings: held state freezes
		'{ROW_WRITE, REG_DEBOUNCE,    16'hFFFF, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_WRITE, REG_LONG_PRESS,  16'hFFFF, 1'b1, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b1, 1'b0, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b0, 1'b1, 1'b0, 6'b000000},
		'{ROW_TICK,  REG_DEBOUNCE,    16'h0000, 1'b1, 1'b1, 1'b0, 6'b000000}
	};

	// ------------------------------------------------------------------
	// Button model state and settings as the core should hold them
	// ------------------------------------------------------------------
	logic [CFG_W-1:0]   debounce_cfg;
	logic [CFG_W-1:0]   long_cfg;
	logic               last_raw_q [NUM_BUTTONS];
	logic [COUNT_W-1:0] stable_cnt [NUM_BUTTONS];
	logic               qual_level [NUM_BUTTONS];
	logic [COUNT_W-1:0] hold_cnt   [NUM_BUTTONS];
	logic               long_fired [NUM_BUTTONS];

	result_t pending_reports [$];  // expected result per accepted tick
	int      fail_count;

	// idle odds: 0 = never, n = one chance in n per tick (sender) or cycle (sink) to start a burst
	int sender_odds;
	int sink_odds;

	// episode generator: current intended level and ticks left in the run
	logic level_now [NUM_BUTTONS];
	int   run_left  [NUM_BUTTONS];

	function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	// One tick of one button.
	function automatic lane_evt_t advance_button(input int b, input logic raw);
		lane_evt_t ev;
		ev = '0;
		// hold count runs in every state, also while released
		hold_cnt[b] = sat_bump(hold_cnt[b]);
		if (raw != last_raw_q[b]) begin
			last_raw_q[b] = raw;
			stable_cnt[b] = '0;
		end else begin
			stable_cnt[b] = sat_bump(stable_cnt[b]);
		end
		if (stable_cnt[b] >= debounce_cfg) begin
			if (raw != qual_level[b]) begin
				qual_level[b] = raw;
				if (!raw) begin
					// qualified press restarts the hold
					hold_cnt[b]   = '0;
					long_fired[b] = 1'b0;
				end else if (hold_cnt[b] >= long_cfg) begin
					ev.long_ev = !long_fired[b];
				end else begin
					// short depends on held time only, even after long fired
					ev.short_ev = 1'b1;
				end
			end
			if (!qual_level[b] && !long_fired[b] && hold_cnt[b] >= long_cfg) begin
				long_fired[b] = 1'b1;
				ev.long_ev    = 1'b1;
			end
		end
		ev.held = !qual_level[b];
		return ev;
	endfunction

	function automatic result_t predict_tick(input logic tare, input logic timer);
		lane_evt_t t_ev;
		lane_evt_t m_ev;
		result_t   r;
		t_ev = advance_button(BTN_TARE, tare);
		m_ev = advance_button(BTN_TIMER, timer);
		r.tare_short  = t_ev.short_ev;
		r.tare_long   = t_ev.long_ev;
		r.timer_short = m_ev.short_ev;
		r.timer_long  = m_ev.long_ev;
		r.tare_held   = t_ev.held;
		r.timer_held  = m_ev.held;
		return r;
	endfunction

	task automatic reset_model();
		debounce_cfg = DEBOUNCE_RESET;
		long_cfg     = LONG_PRESS_RESET;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			last_raw_q[b] = 1'b1;
			stable_cnt[b] = '0;
			qual_level[b] = 1'b1;
			hold_cnt[b]   = '0;
			long_fired[b] = 1'b0;
			level_now[b]  = 1'b1;
			run_left[b]   = 0;
		end
	endtask

	// ------------------------------------------------------------------
	// Drivers. valid is left high between back-to-back transactions and
	// only lowered when a gap starts, so it never gets two updates in one
	// time step.
	// ------------------------------------------------------------------
	task automatic send_tick(input logic tare, input logic timer, input bit typed,
			input result_t want);
		int      gap;
		result_t predicted;
		cfg_ch.valid <= 1'b0;
		if (sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
			gap = $urandom_range(1, 9);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.tare_level  <= tare;
		in_ch.timer_level <= timer;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		// transaction taken at this edge
		predicted = predict_tick(tare, timer);
		pending_reports.push_back(typed ? want : predicted);
	endtask

	// Hold the tick channel until every result is back and the core is idle.
	task automatic drain_reports();
		in_ch.valid  <= 1'b0;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
			input logic [CFG_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= reg_index;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (reg_index)
			REG_DEBOUNCE:   debounce_cfg = value;
			REG_LONG_PRESS: long_cfg     = value;
			default: ;  // unmapped index, dropped
		endcase
	endtask

	task automatic configure(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng);
		drain_reports();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_LONG_PRESS, lng);
	endtask

	// Run lengths: some bounce, some short holds, some long holds, scaled
	// to the settings so that presses qualify, but not at full-scale debounce.
	function automatic int pick_run_length();
		int span;
		int roll;
		span = int'(debounce_cfg) + int'(long_cfg);
		if (span > 120)
			span = 120;
		roll = $urandom_range(0, 9);
		if (roll < 3)
			return $urandom_range(1, 2);
		if (roll < 6)
			return $urandom_range(1, span + 1);
		return $urandom_range(span, 2 * span + 4);
	endfunction

	task automatic run_episodes(input int count);
		logic lvl [NUM_BUTTONS];
		for (int k = 0; k < count; k++) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				if (run_left[b] == 0) begin
					level_now[b] = !level_now[b];
					run_left[b]  = pick_run_length();
				end
				run_left[b]--;
				// occasional noise tick on top of the episode
				lvl[b] = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1))
				                                      : level_now[b];
			end
			send_tick(lvl[BTN_TARE], lvl[BTN_TIMER], 1'b0, '0);
		end
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0:       return 0;   // stretch with no idling
			1:       return 12;
			default: return 3;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin : clock_gen
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Result sink with random stall bursts
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && sink_odds != 0 && $urandom_range(1, sink_odds) == 1)
				stall_left = $urandom_range(1, 9);
			if (stall_left != 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: each result transaction against the oldest expected
	// ------------------------------------------------------------------
	task automatic check_field(input string field, input logic want, input logic got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %0b got %0b", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t seen;
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			seen.tare_short  = out_ch.tare_short;
			seen.tare_long   = out_ch.tare_long;
			seen.timer_short = out_ch.timer_short;
			seen.timer_long  = out_ch.timer_long;
			seen.tare_held   = out_ch.tare_held;
			seen.timer_held  = out_ch.timer_held;
			if (pending_reports.size() == 0) begin
				fail_count++;
				$display("%0t: result expected none got %b", $time, seen);
			end else begin
				want = pending_reports.pop_front();
				check_field("tare_short",  want.tare_short,  seen.tare_short);
				check_field("tare_long",   want.tare_long,   seen.tare_long);
				check_field("timer_short", want.timer_short, seen.timer_short);
				check_field("timer_long",  want.timer_long,  seen.timer_long);
				check_field("tare_held",   want.tare_held,   seen.tare_held);
				check_field("timer_held",  want.timer_held,  seen.timer_held);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without a transaction on any channel
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [CFG_W-1:0] deb;
		logic [CFG_W-1:0] lng;
		fail_count  = 0;
		sender_odds = 0;
		sink_odds   = 0;
		reset_model();
		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.tare_level  <= 1'b1;
		in_ch.timer_level <= 1'b1;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_DEBOUNCE;
		cfg_ch.data       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, light idling on both sides
		sender_odds = 4;
		sink_odds   = 4;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_reports();
				write_reg(directed_rows[i].reg_index, directed_rows[i].value);
			end else begin
				send_tick(directed_rows[i].tare, directed_rows[i].timer,
				          directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// random episodes; settings change between phases while buttons may
		// still be held, so thresholds also move under a running press
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					deb = '0;
					lng = CFG_W'(1);
				end
				1: begin
					deb = CFG_MAX;
					lng = CFG_W'($urandom_range(1, 40));
				end
				default: begin
					deb = ($urandom_range(0, 2) != 0) ? CFG_W'($urandom_range(0, 3))
					                                  : CFG_W'($urandom_range(4, 12));
					lng = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(1, 12))
					                                  : CFG_W'($urandom_range(13, 40));
				end
			endcase
			configure(deb, lng);
			sender_odds = pick_odds();
			sink_odds   = pick_odds();
			run_episodes((ph == 1) ? SLOW_TICKS : PHASE_TICKS);
		end

		// soak: both buttons held past the long threshold; long fires once
		// and the rest of the hold stays quiet
		sender_odds = 0;
		sink_odds   = 0;
		configure('0, SOAK_LONG);
		repeat (SOAK_TICKS) send_tick(1'b0, 1'b0, 1'b0, '0);

		// closing stretch without idling
		configure(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(1, 20)));
		run_episodes(TAIL_TICKS);

		in_ch.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
